>>> hw/rtl/swhdu_pkg.sv
// Package for the single-wire half-duplex UART.
// Holds the payload structs, request codes, config indexes and phase enums.
// No dependencies.
package swhdu_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_SEND = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_BIT_TICKS = 2'd0;
    localparam logic [1:0] CFG_GUARD_TICKS    = 2'd1;

    localparam logic [7:0]  HALF_BIT_TICKS_RST = 8'd4;
    localparam logic [15:0] GUARD_TICKS_RST    = 16'd1000;

    localparam logic [3:0] DATA_BITS = 4'd8;

    typedef enum logic {
        RX_IDLE = 1'b0,
        RX_RECV = 1'b1
    } t_rx_phase;

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_SEND  = 2'd1,
        TX_GUARD = 2'd2
    } t_tx_phase;

    typedef struct packed {
        logic [1:0] req_type;
        logic       line_level;
        logic [7:0] send_byte;
    } t_in_item;

    typedef struct packed {
        logic       line_drive_enable;
        logic       line_out;
        logic [7:0] read_data;
        logic       rx_ready;
        logic       tx_busy;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  half_bit_ticks;
        logic [15:0] guard_ticks;
    } t_cfg;

endpackage

>>> hw/rtl/single_wire_half_duplex_uart.sv
// Top level of the single-wire half-duplex 8N1 UART.
// Depends on swhdu_pkg and swhdu_engine.
//
// Each input transaction is one timer tick (with a line sample), a read of the
// one-byte receive buffer, or a request to send a byte; every transaction
// yields exactly one result showing the line drive, the read byte, and the
// ready and busy flags after it. Throughput is one transaction per clock while
// the output is not stalled. The transaction lands in an input register, the
// engine's single pass of counter and shift logic runs off that register, and
// the result is captured in an output register. The output register decouples
// the channels, so a new transaction is taken while a result waits; input
// stall rises only when both registers are full and the output is stalled.
// Configuration (half-bit length, guard gap) is written through a separate
// valid/ready port that is always ready; write it only while no transaction
// is in flight.
module single_wire_half_duplex_uart (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // transaction input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swhdu_pkg::t_in_item  i_in,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swhdu_pkg::t_out_item o_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import swhdu_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;

    logic      out_load;
    logic      step;
    t_out_item result;

    // output register can take a new result when empty or draining
    assign out_load   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks <= HALF_BIT_TICKS_RST;
            r_cfg.guard_ticks    <= GUARD_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HALF_BIT_TICKS) begin
                r_cfg.half_bit_ticks <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_GUARD_TICKS) begin
                r_cfg.guard_ticks <= i_cfg_data;
            end
        end
    end

    swhdu_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

`ifndef SYNTHESIS
    a_no_drop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("result lost while output stalled");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    a_result_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed transaction produced no result");
`endif

endmodule

>>> hw/rtl/swhdu_engine.sv
// UART engine: receive and transmit state plus the per-transaction step logic.
// Depends on swhdu_pkg.
module swhdu_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  swhdu_pkg::t_in_item  i_item,
    input  swhdu_pkg::t_cfg      i_cfg,
    output swhdu_pkg::t_out_item o_result
);
    import swhdu_pkg::*;

    t_rx_phase   r_rx_phase,     n_rx_phase;
    logic [3:0]  r_rx_bit_index, n_rx_bit_index;
    logic [9:0]  r_rx_timer,     n_rx_timer;
    logic [7:0]  r_rx_shift,     n_rx_shift;
    logic [7:0]  r_rx_buffer,    n_rx_buffer;
    logic        r_rx_flag,      n_rx_flag;
    logic        r_prev_level,   n_prev_level;
    t_tx_phase   r_tx_phase,     n_tx_phase;
    logic [15:0] r_tx_timer,     n_tx_timer;
    logic [7:0]  r_tx_shift,     n_tx_shift;
    logic [3:0]  r_tx_bit_count, n_tx_bit_count;

    logic [7:0]  half_len;
    logic [8:0]  two_half;
    logic [9:0]  three_half;
    logic [15:0] tx_dec;
    logic [9:0]  rx_dec;
    logic [3:0]  tx_cnt_inc;
    logic [7:0]  read_data;
    logic        tx_level;
    logic [3:0]  tx_sel;

    // zero half-bit length behaves as one
    assign half_len   = (i_cfg.half_bit_ticks == 8'd0) ? 8'd1 : i_cfg.half_bit_ticks;
    assign two_half   = {half_len, 1'b0};
    assign three_half = {1'b0, two_half} + {2'b00, half_len};

    assign tx_dec     = (r_tx_timer != 16'd0) ? r_tx_timer - 16'd1 : 16'd0;
    assign rx_dec     = (r_rx_timer != 10'd0) ? r_rx_timer - 10'd1 : 10'd0;
    assign tx_cnt_inc = r_tx_bit_count + 4'd1;

    always_comb begin
        n_rx_phase     = r_rx_phase;
        n_rx_bit_index = r_rx_bit_index;
        n_rx_timer     = r_rx_timer;
        n_rx_shift     = r_rx_shift;
        n_rx_buffer    = r_rx_buffer;
        n_rx_flag      = r_rx_flag;
        n_prev_level   = r_prev_level;
        n_tx_phase     = r_tx_phase;
        n_tx_timer     = r_tx_timer;
        n_tx_shift     = r_tx_shift;
        n_tx_bit_count = r_tx_bit_count;
        read_data      = 8'd0;

        if (i_step) begin
            unique case (i_item.req_type)
                REQ_TICK: begin
                    // transmitter first; receiver sees its updated phase
                    unique case (r_tx_phase)
                        TX_SEND: begin
                            n_tx_timer = tx_dec;
                            if (tx_dec == 16'd0) begin
                                if (tx_cnt_inc <= DATA_BITS) begin
                                    n_tx_bit_count = tx_cnt_inc;
                                    n_tx_timer     = {7'd0, two_half};
                                end else begin
                                    n_tx_bit_count = 4'd0;
                                    if (i_cfg.guard_ticks == 16'd0) begin
                                        n_tx_phase = TX_IDLE;
                                    end else begin
                                        n_tx_phase = TX_GUARD;
                                        n_tx_timer = i_cfg.guard_ticks;
                                    end
                                end
                            end
                        end
                        TX_GUARD: begin
                            n_tx_timer = tx_dec;
                            if (tx_dec == 16'd0) begin
                                n_tx_phase = TX_IDLE;
                            end
                        end
                        default: begin
                            n_tx_phase = TX_IDLE;
                        end
                    endcase

                    if (r_rx_phase == RX_RECV) begin
                        n_rx_timer = rx_dec;
                        if (rx_dec == 10'd0) begin
                            if (r_rx_bit_index < DATA_BITS) begin
                                n_rx_shift[r_rx_bit_index[2:0]] = i_item.line_level;
                                n_rx_bit_index = r_rx_bit_index + 4'd1;
                                n_rx_timer     = {1'b0, two_half};
                            end else begin
                                // stop bit; full buffer drops the byte
                                if (i_item.line_level && !r_rx_flag) begin
                                    n_rx_buffer = r_rx_shift;
                                    n_rx_flag   = 1'b1;
                                end
                                n_rx_phase     = RX_IDLE;
                                n_rx_bit_index = 4'd0;
                            end
                        end
                    end else if (n_tx_phase == TX_IDLE && r_prev_level &&
                                 !i_item.line_level) begin
                        n_rx_phase     = RX_RECV;
                        n_rx_bit_index = 4'd0;
                        n_rx_timer     = three_half;
                    end
                    n_prev_level = i_item.line_level;
                end
                REQ_READ: begin
                    read_data   = r_rx_buffer;
                    n_rx_buffer = 8'd0;
                    n_rx_flag   = 1'b0;
                end
                REQ_SEND: begin
                    if (r_tx_phase == TX_IDLE) begin
                        n_tx_phase     = TX_SEND;
                        n_tx_shift     = i_item.send_byte;
                        n_tx_bit_count = 4'd0;
                        n_tx_timer     = {7'd0, two_half};
                        // abort any receive in progress
                        n_rx_phase     = RX_IDLE;
                        n_rx_bit_index = 4'd0;
                        n_rx_timer     = 10'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // bit count 0 is the start bit
    assign tx_sel   = n_tx_bit_count - 4'd1;
    assign tx_level = (n_tx_bit_count == 4'd0 || n_tx_bit_count > DATA_BITS) ? 1'b0 :
                      n_tx_shift[tx_sel[2:0]];

    always_comb begin
        o_result.line_drive_enable = (n_tx_phase == TX_SEND);
        o_result.line_out          = (n_tx_phase == TX_SEND) ? tx_level : 1'b1;
        o_result.read_data         = read_data;
        o_result.rx_ready          = n_rx_flag;
        o_result.tx_busy           = (n_tx_phase != TX_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase     <= RX_IDLE;
            r_rx_bit_index <= 4'd0;
            r_rx_timer     <= 10'd0;
            r_rx_shift     <= 8'd0;
            r_rx_buffer    <= 8'd0;
            r_rx_flag      <= 1'b0;
            r_prev_level   <= 1'b1;
            r_tx_phase     <= TX_IDLE;
            r_tx_timer     <= 16'd0;
            r_tx_shift     <= 8'd0;
            r_tx_bit_count <= 4'd0;
        end else begin
            r_rx_phase     <= n_rx_phase;
            r_rx_bit_index <= n_rx_bit_index;
            r_rx_timer     <= n_rx_timer;
            r_rx_shift     <= n_rx_shift;
            r_rx_buffer    <= n_rx_buffer;
            r_rx_flag      <= n_rx_flag;
            r_prev_level   <= n_prev_level;
            r_tx_phase     <= n_tx_phase;
            r_tx_timer     <= n_tx_timer;
            r_tx_shift     <= n_tx_shift;
            r_tx_bit_count <= n_tx_bit_count;
        end
    end

`ifndef SYNTHESIS
    a_rx_only_when_tx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_phase == RX_RECV) |-> (r_tx_phase == TX_IDLE))
        else $error("receive active while transmitter busy");

    a_tx_count_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_phase != TX_SEND) |-> (r_tx_bit_count == 4'd0))
        else $error("tx bit count nonzero outside send");

    a_counts_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_bit_count <= DATA_BITS) && (r_rx_bit_index <= DATA_BITS))
        else $error("bit counter out of range");

    a_flag_set_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rx_flag) |-> $past(i_step && i_item.req_type == REQ_TICK))
        else $error("ready flag set by a non-tick transaction");

    a_flag_clear_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.req_type == REQ_READ) |=> !r_rx_flag)
        else $error("ready flag survived a read");
`endif

endmodule

>>> verif/single_wire_half_duplex_uart_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for single_wire_half_duplex_uart: directed and random UART traffic.
// Depends on swhdu_pkg and the single_wire_half_duplex_uart RTL.
module single_wire_half_duplex_uart_tb;
    import swhdu_pkg::*;

    // request code the block must treat as a no-op
    localparam logic [1:0] REQ_NONE = 2'd3;

    // ---------------------------------------------------------------- DUT ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in        = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    single_wire_half_duplex_uart DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------ scoreboard storage
    t_in_item  req_q[$];        // transactions waiting to be driven
    t_out_item status_due_q[$]; // predicted line/flag status, oldest first

    int  err_count      = 0;
    int  queued_items   = 0;
    int  items_taken    = 0;
    int  results_seen   = 0;
    int  sends_started  = 0;
    int  frames_stored  = 0;
    int  frames_dropped = 0;
    bit  idle_off       = 1'b0; // set to run both channels back to back

    // ------------------------------------------------------- UART state mirror
    logic [7:0]  cfg_half;
    logic [15:0] cfg_guard;

    t_rx_phase   rx_mode;
    logic [3:0]  rx_bits;
    logic [9:0]  rx_cnt;
    logic [7:0]  rx_sr;
    logic [7:0]  rx_hold;
    logic        rx_full;
    logic        last_level;
    t_tx_phase   tx_mode;
    logic [15:0] tx_cnt;
    logic [7:0]  tx_sr;
    logic [3:0]  tx_bits;

    // a half-bit length of zero behaves as one tick
    function automatic logic [15:0] half_eff();
        return (cfg_half == 8'd0) ? 16'd1 : {8'd0, cfg_half};
    endfunction

    // Advance the mirror by one transaction and return the status it leaves.
    task automatic compute_uart_status(input t_in_item it, output t_out_item st);
        logic [7:0] rd;
        logic       lvl;
        rd  = 8'd0;
        lvl = it.line_level;
        case (it.req_type)
            REQ_TICK: begin
                // transmitter steps first; receiver sees its updated phase
                case (tx_mode)
                    TX_SEND: begin
                        if (tx_cnt != 16'd0) tx_cnt--;
                        if (tx_cnt == 16'd0) begin
                            tx_bits++;
                            if (tx_bits <= DATA_BITS) begin
                                tx_cnt = half_eff() << 1;
                            end else begin
                                tx_bits = 4'd0;
                                if (cfg_guard == 16'd0) begin
                                    tx_mode = TX_IDLE;
                                end else begin
                                    tx_mode = TX_GUARD;
                                    tx_cnt  = cfg_guard;
                                end
                            end
                        end
                    end
                    TX_GUARD: begin
                        if (tx_cnt != 16'd0) tx_cnt--;
                        if (tx_cnt == 16'd0) tx_mode = TX_IDLE;
                    end
                    default: tx_mode = TX_IDLE;
                endcase

                if (rx_mode == RX_RECV) begin
                    if (rx_cnt != 10'd0) rx_cnt--;
                    if (rx_cnt == 10'd0) begin
                        if (rx_bits < DATA_BITS) begin
                            rx_sr[rx_bits[2:0]] = lvl;
                            rx_bits++;
                            rx_cnt = 10'(half_eff() << 1);
                        end else begin
                            // stop bit: keep the byte only if high and buffer empty
                            if (lvl && !rx_full) begin
                                rx_hold = rx_sr;
                                rx_full = 1'b1;
                                frames_stored++;
                            end else if (lvl) begin
                                frames_dropped++;
                            end
                            rx_mode = RX_IDLE;
                            rx_bits = 4'd0;
                        end
                    end
                end else if (tx_mode == TX_IDLE && last_level && !lvl) begin
                    rx_mode = RX_RECV;
                    rx_bits = 4'd0;
                    rx_cnt  = 10'(3 * half_eff());
                end
                last_level = lvl;
            end
            REQ_READ: begin
                rd      = rx_hold;
                rx_hold = 8'd0;
                rx_full = 1'b0;
            end
            REQ_SEND: begin
                // ignored while busy; otherwise kills any receive in flight
                if (tx_mode == TX_IDLE) begin
                    tx_mode = TX_SEND;
                    tx_sr   = it.send_byte;
                    tx_bits = 4'd0;
                    tx_cnt  = half_eff() << 1;
                    rx_mode = RX_IDLE;
                    rx_bits = 4'd0;
                    rx_cnt  = 10'd0;
                    sends_started++;
                end
            end
            default: ;
        endcase

        st.line_drive_enable = (tx_mode == TX_SEND);
        if (tx_mode != TX_SEND)
            st.line_out = 1'b1;
        else if (tx_bits == 4'd0 || tx_bits > DATA_BITS)
            st.line_out = 1'b0;               // start bit
        else
            st.line_out = tx_sr[3'(tx_bits - 4'd1)];
        st.read_data = rd;
        st.rx_ready  = rx_full;
        st.tx_busy   = (tx_mode != TX_IDLE);
    endtask

    // Per-transaction wait: none with idle_off set; else half the time none, otherwise a random 0..14.
    function automatic int wait_draw();
        if (idle_off || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // ------------------------------------------------------------------ driver
    // Presents queued transactions; valid is held until the DUT takes it.
    logic      drv_valid_nxt;
    int        drv_gap = 0;
    t_out_item drv_status;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            drv_valid_nxt = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                // transaction accepted: predict its status right away
                compute_uart_status(i_in, drv_status);
                status_due_q.push_back(drv_status);
                items_taken++;
                drv_valid_nxt = 1'b0;
                drv_gap = wait_draw();
            end
            if (!drv_valid_nxt) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (req_q.size() != 0) begin
                    i_in <= req_q.pop_front();
                    drv_valid_nxt = 1'b1;
                end
            end
            i_in_valid <= drv_valid_nxt;
        end
    end

    // ----------------------------------------------------------------- monitor
    // Checks every accepted result against the oldest prediction and applies
    // random back-pressure on the result channel.
    int        mon_hold = 0;
    t_out_item mon_exp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            mon_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (status_due_q.size() == 0) begin
                    $error("result with no transaction pending: %h", o_out);
                    err_count++;
                end else begin
                    mon_exp = status_due_q.pop_front();
                    if (o_out.line_drive_enable !== mon_exp.line_drive_enable) begin
                        $error("line_drive_enable: expected %0d, actual %0d",
                               mon_exp.line_drive_enable, o_out.line_drive_enable);
                        err_count++;
                    end
                    if (o_out.line_out !== mon_exp.line_out) begin
                        $error("line_out: expected %0d, actual %0d",
                               mon_exp.line_out, o_out.line_out);
                        err_count++;
                    end
                    if (o_out.read_data !== mon_exp.read_data) begin
                        $error("read_data: expected %02h, actual %02h",
                               mon_exp.read_data, o_out.read_data);
                        err_count++;
                    end
                    if (o_out.rx_ready !== mon_exp.rx_ready) begin
                        $error("rx_ready: expected %0d, actual %0d",
                               mon_exp.rx_ready, o_out.rx_ready);
                        err_count++;
                    end
                    if (o_out.tx_busy !== mon_exp.tx_busy) begin
                        $error("tx_busy: expected %0d, actual %0d",
                               mon_exp.tx_busy, o_out.tx_busy);
                        err_count++;
                    end
                end
                mon_hold = wait_draw();
            end
            if (mon_hold > 0) begin
                mon_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------- stimulus helpers
    task automatic queue_req(input logic [1:0] rt, input logic lvl, input logic [7:0] b);
        t_in_item it;
        it.req_type   = rt;
        it.line_level = lvl;
        it.send_byte  = b;
        req_q.push_back(it);
        queued_items++;
    endtask

    task automatic queue_ticks(input int n, input logic lvl);
        for (int k = 0; k < n; k++)
            queue_req(REQ_TICK, lvl, 8'($urandom));
    endtask

    // random line levels
    task automatic queue_noise(input int n);
        for (int k = 0; k < n; k++)
            queue_req(REQ_TICK, 1'($urandom), 8'($urandom));
    endtask

    // Line waveform of a frame: idle high, start, 8 data bits LSB first, stop.
    // Only the first 'periods' bit periods are sent, so a frame can be cut short.
    task automatic queue_rx_frame(input logic [7:0] data, input logic stop_lvl,
                                  input int periods);
        int   per;
        logic lvl;
        per = 2 * half_eff();
        queue_ticks($urandom_range(1, 3), 1'b1);
        for (int k = 0; k < periods; k++) begin
            if (k == 0)
                lvl = 1'b0;
            else if (k <= 8)
                lvl = data[k - 1];
            else
                lvl = stop_lvl;
            queue_ticks(per, lvl);
        end
    endtask

    // Send a byte and tick through the whole frame and guard gap with line noise.
    task automatic queue_send_run(input logic [7:0] b);
        queue_req(REQ_SEND, 1'($urandom), b);
        queue_noise(18 * half_eff() + cfg_guard + $urandom_range(0, 3));
        queue_ticks(2, 1'b1);
    endtask

    // Mostly well-formed frames and sends with random content, some noise.
    task automatic queue_mix(input int n);
        int          target;
        int unsigned pick;
        target = queued_items + n;
        while (queued_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_rx_frame(8'($urandom), ($urandom_range(0, 9) != 0), 10);
            else if (pick < 62)
                queue_req(REQ_READ, 1'($urandom), 8'($urandom));
            else if (pick < 72)
                queue_send_run(8'($urandom));
            else if (pick < 80)
                queue_noise($urandom_range(1, 6));
            else if (pick < 84)
                queue_req(REQ_NONE, 1'($urandom), 8'($urandom));
            else if (pick < 93) begin
                // receive cut off by a send
                queue_rx_frame(8'($urandom), 1'b1, $urandom_range(1, 9));
                queue_send_run(8'($urandom));
            end else begin
                // send that may land while still busy
                queue_req(REQ_SEND, 1'($urandom), 8'($urandom));
                queue_noise($urandom_range(0, 4));
            end
        end
    endtask

    // Block is idle once nothing is queued, presented or awaiting a result.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_q.size() != 0 || i_in_valid || status_due_q.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HALF_BIT_TICKS)
            cfg_half = val[7:0];
        else
            cfg_guard = val;
    endtask

    task automatic run_phase(input logic [7:0] half, input logic [15:0] guard,
                             input bit quiet, input int n);
        write_reg(CFG_HALF_BIT_TICKS, {8'd0, half});
        write_reg(CFG_GUARD_TICKS, guard);
        idle_off = quiet;
        queue_mix(n);
        wait_drained();
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        // mirror starts at the reset state
        cfg_half   = HALF_BIT_TICKS_RST;
        cfg_guard  = GUARD_TICKS_RST;
        rx_mode    = RX_IDLE;
        rx_bits    = 4'd0;
        rx_cnt     = 10'd0;
        rx_sr      = 8'd0;
        rx_hold    = 8'd0;
        rx_full    = 1'b0;
        last_level = 1'b1;
        tx_mode    = TX_IDLE;
        tx_cnt     = 16'd0;
        tx_sr      = 8'd0;
        tx_bits    = 4'd0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty read, unknown code, a falling edge starts a receive
        queue_req(REQ_READ, 1'b0, 8'hFF);
        queue_req(REQ_NONE, 1'b1, 8'hFF);
        queue_ticks(1, 1'b1);
        queue_ticks(2, 1'b0);
        wait_drained();

        // zero half-bit length and zero guard
        write_reg(CFG_HALF_BIT_TICKS, 16'd0);
        write_reg(CFG_GUARD_TICKS, 16'd0);
        queue_req(REQ_SEND, 1'b0, 8'hFF);   // aborts the receive in flight
        queue_req(REQ_SEND, 1'b1, 8'h00);   // busy, ignored
        queue_ticks(19, 1'b0);              // receiver off, edge not seen later
        queue_ticks(2, 1'b1);
        queue_rx_frame(8'h80, 1'b1, 10);
        queue_rx_frame(8'hFF, 1'b1, 10);    // buffer full: dropped
        queue_req(REQ_READ, 1'b1, 8'h00);
        queue_req(REQ_READ, 1'b0, 8'h00);
        queue_rx_frame(8'h01, 1'b0, 10);    // low stop bit: discarded
        queue_rx_frame(8'h7E, 1'b1, 5);
        queue_send_run(8'h5A);
        queue_rx_frame(8'h00, 1'b1, 10);
        queue_req(REQ_READ, 1'b1, 8'hFF);
        wait_drained();

        // random traffic over several settings, one without any idling
        run_phase(8'd1, 16'd5, 1'b0, 50);
        run_phase(8'd2, 16'd0, 1'b1, 50);
        run_phase(8'd3, 16'd40, 1'b0, 50);
        run_phase(8'd1, 16'd1, 1'b0, 50);
        run_phase(8'd2, 16'd17, 1'b0, 50);

        // largest settings: only a short run, the guard is never waited out
        write_reg(CFG_HALF_BIT_TICKS, 16'd255);
        write_reg(CFG_GUARD_TICKS, 16'hFFFF);
        idle_off = 1'b0;
        queue_ticks(1, 1'b1);
        queue_ticks(3, 1'b0);
        queue_req(REQ_SEND, 1'b0, 8'hA5);
        queue_noise(20);
        queue_req(REQ_READ, 1'b0, 8'h00);
        queue_req(REQ_SEND, 1'b1, 8'h3C);
        queue_noise(4);
        wait_drained();

        // let any late output surface
        repeat (8) @(posedge i_clk);

        $display("Covered %0d transactions (%0d results checked) over 8 register settings.",
                 items_taken, results_seen);
        $display("Sends started: %0d, frames captured: %0d, frames dropped on full buffer: %0d.",
                 sends_started, frames_stored, frames_dropped);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $error("timeout with %0d results outstanding", status_due_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
